// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the plane scaler setup block
// Transaction structs, pipeline payloads, write slots, register offsets and
// the three filter coefficient sets.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM) + 1;   // size fields
  localparam int POS_W     = $clog2(MAX_DIM);       // coordinate fields
  localparam int SCALE_SH  = 13;                    // ratio scale of 8192
  localparam int NUM_W     = DIM_W + SCALE_SH;      // ratio dividend
  localparam int AREA_W    = 2 * DIM_W;
  localparam int HALF_W    = 16;
  localparam int ADDR_W    = 11;
  localparam int VAL_W     = 32;
  localparam int DIV_STEPS_DEF = 2;                 // quotient bits per stage

  localparam int WRITES_PER_RUN = 12;
  localparam int CNT_W          = $clog2(WRITES_PER_RUN);

  // write slots within one run
  localparam logic [CNT_W-1:0] IDX_RATIO = CNT_W'(0);
  localparam logic [CNT_W-1:0] IDX_COEF0 = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDX_ISIZE = CNT_W'(9);
  localparam logic [CNT_W-1:0] IDX_OSIZE = CNT_W'(10);
  localparam logic [CNT_W-1:0] IDX_COORD = CNT_W'(11);

  // register map
  localparam logic [ADDR_W-1:0] PLANE_BASE = ADDR_W'(12'h400);
  localparam logic [7:0] OFF_SR    = 8'h0C;
  localparam logic [7:0] OFF_COEF0 = 8'h10;
  localparam logic [7:0] OFF_ISIZE = 8'h04;
  localparam logic [7:0] OFF_OSIZE = 8'h08;
  localparam logic [7:0] OFF_COOR  = 8'h54;

  typedef enum logic [1:0] {
    SET_SHARP  = 2'd0,
    SET_LINEAR = 2'd1,
    SET_SMOOTH = 2'd2
  } coef_set_t;

  localparam logic [31:0] COEF_SHARP [8] = '{
    32'h00400000, 32'hFC3E07FF, 32'hFA3810FE, 32'hF9301BFC,
    32'hFA2626FA, 32'hFC1B30F9, 32'hFE1038FA, 32'hFF073EFC};
  localparam logic [31:0] COEF_LINEAR [8] = '{
    32'h00400000, 32'h00380800, 32'h00301000, 32'h00281800,
    32'h00202000, 32'h00182800, 32'h00103000, 32'h00083800};
  localparam logic [31:0] COEF_SMOOTH [8] = '{
    32'h10201000, 32'h0E1E1202, 32'h0C1C1404, 32'h0A1A1606,
    32'h08181808, 32'h06161A0A, 32'h04141C0C, 32'h02121E0E};

  typedef struct packed {
    logic [1:0]       plane_sel;
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [POS_W-1:0] dst_left;
    logic [POS_W-1:0] dst_top;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] reg_addr;
    logic [VAL_W-1:0]  reg_value;
    logic              last_write;
  } wr_t;

  // per-request context carried alongside the dividers
  typedef struct packed {
    logic [1:0]       plane;
    coef_set_t        cset;
    logic [VAL_W-1:0] isize;
    logic [VAL_W-1:0] osize;
    logic [VAL_W-1:0] coord;
  } ctx_t;

  // one restoring divider lane: num shifts out dividend bits, in quotient bits
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIM_W-1:0] rem;
    logic [DIM_W-1:0] den;
    logic             den_zero;
  } div_lane_t;

  typedef struct packed {
    ctx_t      ctx;
    div_lane_t h;
    div_lane_t v;
  } div_pay_t;

  function automatic logic [31:0] coef_word(coef_set_t s, logic [2:0] k);
    logic [31:0] w;
    case (s)
      SET_SHARP:  w = COEF_SHARP[k];
      SET_LINEAR: w = COEF_LINEAR[k];
      SET_SMOOTH: w = COEF_SMOOTH[k];
      default:    w = COEF_SMOOTH[k];
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/pss_prep.sv =====
// ----------------------------------------------------------------------------
// pss_prep: request front end
// Stage 1 forms the source and destination areas; stage 2 picks the
// coefficient set, builds the size and coordinate words and loads the
// ratio dividers.
// ----------------------------------------------------------------------------
module pss_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pss_pkg::req_t     in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output pss_pkg::div_pay_t out_pay
);
  import pss_pkg::*;

  logic              v1_r, v2_r;
  logic              rdy1, rdy2;
  req_t              req1_r;
  logic [AREA_W-1:0] area_src1_r, area_dst1_r;
  div_pay_t          pay2_r, pay2_nxt;

  logic [AREA_W:0]   area_dst2;
  logic [AREA_W+2:0] area_dst5;
  coef_set_t         cset;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      req1_r      <= in_req;
      area_src1_r <= AREA_W'(in_req.src_width) * AREA_W'(in_req.src_height);
      area_dst1_r <= AREA_W'(in_req.dst_width) * AREA_W'(in_req.dst_height);
    end
  end

  // truncated quotient <= 1 iff src < 2*dst, <= 4 iff src < 5*dst;
  // a zero destination area fails both and lands on the smooth set
  always_comb begin
    area_dst2 = {area_dst1_r, 1'b0};
    area_dst5 = {area_dst1_r, 2'b00} + (AREA_W+3)'(area_dst1_r);
    if ((AREA_W+1)'(area_src1_r) < area_dst2) begin
      cset = SET_SHARP;
    end else if ((AREA_W+3)'(area_src1_r) < area_dst5) begin
      cset = SET_LINEAR;
    end else begin
      cset = SET_SMOOTH;
    end
  end

  always_comb begin
    pay2_nxt.ctx.plane = req1_r.plane_sel;
    pay2_nxt.ctx.cset  = cset;
    pay2_nxt.ctx.isize = {HALF_W'(req1_r.src_height) - HALF_W'(1),
                          HALF_W'(req1_r.src_width) - HALF_W'(1)};
    pay2_nxt.ctx.osize = {HALF_W'(req1_r.dst_height) - HALF_W'(1),
                          HALF_W'(req1_r.dst_width) - HALF_W'(1)};
    pay2_nxt.ctx.coord = {HALF_W'(req1_r.dst_top), HALF_W'(req1_r.dst_left)};
    // ceil(src * 8192 / dst) as floor((src * 8192 + dst - 1) / dst)
    pay2_nxt.h.num      = {req1_r.src_width, {SCALE_SH{1'b0}}}
                          + NUM_W'(req1_r.dst_width) - NUM_W'(1);
    pay2_nxt.h.rem      = '0;
    pay2_nxt.h.den      = req1_r.dst_width;
    pay2_nxt.h.den_zero = (req1_r.dst_width == '0);
    pay2_nxt.v.num      = {req1_r.src_height, {SCALE_SH{1'b0}}}
                          + NUM_W'(req1_r.dst_height) - NUM_W'(1);
    pay2_nxt.v.rem      = '0;
    pay2_nxt.v.den      = req1_r.dst_height;
    pay2_nxt.v.den_zero = (req1_r.dst_height == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      pay2_r <= pay2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_pay   = pay2_r;

endmodule

// ===== rtl/pss_div.sv =====
// ----------------------------------------------------------------------------
// pss_div: pipelined ratio dividers
// Two restoring dividers (horizontal, vertical) run side by side, DIV_STEPS
// quotient bits per stage, with the request context riding along.
// ----------------------------------------------------------------------------
module pss_div #(
  parameter int DIV_STEPS = pss_pkg::DIV_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pss_pkg::div_pay_t in_pay,
  output logic              out_valid,
  input  logic              out_ready,
  output pss_pkg::div_pay_t out_pay
);
  import pss_pkg::*;

  localparam int STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

  function automatic div_lane_t div_step(div_lane_t l);
    logic [DIM_W:0] trial;
    div_lane_t      o;
    o     = l;
    trial = {l.rem, l.num[NUM_W-1]};
    if (trial >= {1'b0, l.den}) begin
      trial = trial - {1'b0, l.den};
      o.num = {l.num[NUM_W-2:0], 1'b1};
    end else begin
      o.num = {l.num[NUM_W-2:0], 1'b0};
    end
    o.rem = trial[DIM_W-1:0];
    return o;
  endfunction

  div_pay_t          pay_r [STAGES];
  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    div_pay_t stage_in, stage_nxt;
    logic     v_in;

    if (s == 0) begin : g_first
      assign stage_in = in_pay;
      assign v_in     = in_valid;
    end else begin : g_next
      assign stage_in = pay_r[s-1];
      assign v_in     = vld_r[s-1];
    end

    always_comb begin
      stage_nxt = stage_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < NUM_W) begin
          stage_nxt.h = div_step(stage_nxt.h);
          stage_nxt.v = div_step(stage_nxt.v);
        end
      end
    end

    assign rdy[s] = !vld_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= v_in;
      end
      if (rdy[s] && v_in) begin
        pay_r[s] <= stage_nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign out_pay   = pay_r[STAGES-1];

endmodule

// ===== rtl/pss_seq.sv =====
// ----------------------------------------------------------------------------
// pss_seq: write sequencer
// Holds one finished request and plays out its twelve register writes
// through a registered output stage.
// ----------------------------------------------------------------------------
module pss_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pss_pkg::div_pay_t in_pay,
  output logic              out_valid,
  input  logic              out_stall,
  output pss_pkg::wr_t      out_data
);
  import pss_pkg::*;

  logic             item_v_r;
  ctx_t             ctx_r;
  logic [VAL_W-1:0] ratio_r, ratio_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             out_v_r;
  wr_t              out_r, wr_nxt;
  logic             out_load, item_done;
  logic [7:0]       off;
  logic [2:0]       coef_k;

  assign out_load  = item_v_r && (!out_v_r || !out_stall);
  assign item_done = out_load && (cnt_r == IDX_COORD);
  assign in_ready  = !item_v_r || item_done;

  // a zero divisor reads as all ones
  always_comb begin
    ratio_nxt[VAL_W-1:HALF_W] = in_pay.v.den_zero ? '1 : in_pay.v.num[HALF_W-1:0];
    ratio_nxt[HALF_W-1:0]     = in_pay.h.den_zero ? '1 : in_pay.h.num[HALF_W-1:0];
  end

  always_comb begin
    coef_k = 3'(cnt_r - IDX_COEF0);
    case (cnt_r)
      IDX_RATIO: begin
        off              = OFF_SR;
        wr_nxt.reg_value = ratio_r;
      end
      IDX_ISIZE: begin
        off              = OFF_ISIZE;
        wr_nxt.reg_value = ctx_r.isize;
      end
      IDX_OSIZE: begin
        off              = OFF_OSIZE;
        wr_nxt.reg_value = ctx_r.osize;
      end
      IDX_COORD: begin
        off              = OFF_COOR;
        wr_nxt.reg_value = ctx_r.coord;
      end
      default: begin
        off              = OFF_COEF0 + {3'b000, coef_k, 2'b00};
        wr_nxt.reg_value = coef_word(ctx_r.cset, coef_k);
      end
    endcase
    wr_nxt.reg_addr   = PLANE_BASE + {1'b0, ctx_r.plane, 8'h00} + ADDR_W'(off);
    wr_nxt.last_write = (cnt_r == IDX_COORD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      cnt_r    <= IDX_RATIO;
      out_v_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        item_v_r <= 1'b1;
        cnt_r    <= IDX_RATIO;
      end else if (item_done) begin
        item_v_r <= 1'b0;
      end else if (out_load) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      ctx_r   <= in_pay.ctx;
      ratio_r <= ratio_nxt;
    end
    if (out_load) begin
      out_r <= wr_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/plane_scaler_setup.sv =====
// ----------------------------------------------------------------------------
// plane_scaler_setup: plane scaler register write generator
// Turns one plane scaling request into a run of twelve register writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry requests (plane, source size,
//   destination position and size). out_valid/out_stall/out_data carry the
//   register writes: ratio word, eight coefficient words, input size,
//   output size and coordinates, the last one flagged by last_write.
//   A transaction completes on a rising edge with valid high and stall low.
// Pipeline: the first write of a run passes through two front-end stages,
//   ceil(26 / DIV_STEPS) divider stages, the run holding register and the
//   output register.
// Output: the single write port emits the twelve writes of a run on
//   consecutive cycles while out_stall is low. With DIV_STEPS = 2, up to
//   15 requests can wait in the pipeline behind the run being played out.
// Reset: rst_n (synchronous) empties every stage and drops out_valid.
// Stall: out_stall holds the current write; the pipeline fills behind it
//   and in_stall rises once no stage is free.
// ----------------------------------------------------------------------------
module plane_scaler_setup #(
  parameter int DIV_STEPS = pss_pkg::DIV_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pss_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pss_pkg::wr_t  out_data
);
  import pss_pkg::*;

  logic     prep_ready;
  logic     prep_valid, div_ready;
  div_pay_t prep_pay;
  logic     div_valid, seq_ready;
  div_pay_t div_pay;

  assign in_stall = !prep_ready;

  pss_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (prep_ready),
    .in_req    (in_data),
    .out_valid (prep_valid),
    .out_ready (div_ready),
    .out_pay   (prep_pay)
  );

  pss_div #(
    .DIV_STEPS (DIV_STEPS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (div_ready),
    .in_pay    (prep_pay),
    .out_valid (div_valid),
    .out_ready (seq_ready),
    .out_pay   (div_pay)
  );

  pss_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (seq_ready),
    .in_pay    (div_pay),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a run has no gaps: every write but the last is followed by the next
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_write |=> out_valid)
    else $error("gap inside a write run");

  // the run closes on the coordinate register
  a_last_is_coord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_write |-> out_data.reg_addr[7:0] == OFF_COOR)
    else $error("last write not on coordinate register");

  // the ratio write is followed by the first coefficient of the same plane
  a_ratio_then_coef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.reg_addr[7:0] == OFF_SR
    |=> out_data.reg_addr[7:0] == OFF_COEF0 && $stable(out_data.reg_addr[9:8]))
    else $error("coefficient write does not follow ratio write");

endmodule

// ===== bench/tb_plane_scaler_setup.sv =====
// ----------------------------------------------------------------------------
// tb_plane_scaler_setup: self-checking bench for the plane scaler setup block
// Feeds scaling requests through a valid/stall driver, predicts the twelve
// register writes of every accepted request and checks each write field by
// field. Both sides idle in random bursts, and one long output hold-off
// backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_plane_scaler_setup;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 30;
  localparam int QUIET_ITEMS = 20;
  localparam int NUM_RANDOM  = 90;

  localparam bit [10:0] REG_BASE    = 11'h400;
  localparam bit [10:0] PLANE_STEP  = 11'h100;
  localparam bit [10:0] REG_RATIO   = 11'h00C;
  localparam bit [10:0] REG_COEF0   = 11'h010;
  localparam bit [10:0] REG_INSIZE  = 11'h004;
  localparam bit [10:0] REG_OUTSIZE = 11'h008;
  localparam bit [10:0] REG_COORD   = 11'h054;

  localparam bit [31:0] FILTER_TAB [3][8] = '{
    '{32'h00400000, 32'hFC3E07FF, 32'hFA3810FE, 32'hF9301BFC,
      32'hFA2626FA, 32'hFC1B30F9, 32'hFE1038FA, 32'hFF073EFC},
    '{32'h00400000, 32'h00380800, 32'h00301000, 32'h00281800,
      32'h00202000, 32'h00182800, 32'h00103000, 32'h00083800},
    '{32'h10201000, 32'h0E1E1202, 32'h0C1C1404, 32'h0A1A1606,
      32'h08181808, 32'h06161A0A, 32'h04141C0C, 32'h02121E0E}};

  logic   clk;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  req_t   in_data   = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  wr_t    out_data;

  req_t   scale_reqs[$];
  wr_t    predicted_writes[$];
  int     total_reqs;
  int     reqs_accepted = 0;
  int     cyc = 0;
  int     err_cnt = 0;
  int     in_gap = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  plane_scaler_setup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  function automatic bit [15:0] ceil_ratio(bit [63:0] s, bit [63:0] d);
    if (d == 0) return 16'hFFFF;
    return 16'((s * 64'd8192 + d - 64'd1) / d);
  endfunction

  function automatic bit [31:0] size_pair(bit [63:0] w, bit [63:0] h);
    bit [15:0] lo;
    bit [15:0] hi;
    lo = 16'(w - 64'd1);
    hi = 16'(h - 64'd1);
    return {hi, lo};
  endfunction

  // queue the twelve writes one request turns into
  function automatic void predict_writes(req_t r);
    bit [63:0] src_area;
    bit [63:0] dst_area;
    bit [63:0] quo;
    coef_set_t cs;
    bit [10:0] base;
    wr_t       w;
    src_area = 64'(r.src_width) * 64'(r.src_height);
    dst_area = 64'(r.dst_width) * 64'(r.dst_height);
    quo = (dst_area == 0) ? '1 : src_area / dst_area;
    cs = (quo <= 1) ? SET_SHARP : ((quo <= 4) ? SET_LINEAR : SET_SMOOTH);
    base = REG_BASE + 11'(r.plane_sel) * PLANE_STEP;
    w.last_write = 1'b0;
    w.reg_addr   = base + REG_RATIO;
    w.reg_value  = {ceil_ratio(r.src_height, r.dst_height),
                    ceil_ratio(r.src_width, r.dst_width)};
    predicted_writes.push_back(w);
    for (int k = 0; k < 8; k++) begin
      w.reg_addr  = base + REG_COEF0 + 11'(4 * k);
      w.reg_value = FILTER_TAB[int'(cs)][k];
      predicted_writes.push_back(w);
    end
    w.reg_addr  = base + REG_INSIZE;
    w.reg_value = size_pair(r.src_width, r.src_height);
    predicted_writes.push_back(w);
    w.reg_addr  = base + REG_OUTSIZE;
    w.reg_value = size_pair(r.dst_width, r.dst_height);
    predicted_writes.push_back(w);
    w.reg_addr   = base + REG_COORD;
    w.reg_value  = {4'h0, r.dst_top, 4'h0, r.dst_left};
    w.last_write = 1'b1;
    predicted_writes.push_back(w);
  endfunction

  function automatic req_t mk_req(int p, int sw, int sh, int dl, int dt, int dw, int dh);
    req_t r;
    r.plane_sel  = 2'(p);
    r.src_width  = 13'(sw);
    r.src_height = 13'(sh);
    r.dst_left   = 12'(dl);
    r.dst_top    = 12'(dt);
    r.dst_width  = 13'(dw);
    r.dst_height = 13'(dh);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   mode;
    int   shrink;
    r.plane_sel = 2'($urandom_range(0, 3));
    r.dst_left  = 12'($urandom);
    r.dst_top   = 12'($urandom);
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        // full field range, zero and oversize included
        r.src_width  = 13'($urandom);
        r.src_height = 13'($urandom);
        r.dst_width  = 13'($urandom);
        r.dst_height = 13'($urandom);
      end
      1, 2: begin
        r.src_width  = 13'($urandom_range(1, 64));
        r.src_height = 13'($urandom_range(1, 64));
        r.dst_width  = 13'($urandom_range(1, 64));
        r.dst_height = 13'($urandom_range(1, 64));
      end
      3, 4, 5: begin
        r.src_width  = 13'($urandom_range(1, MAX_DIM));
        r.src_height = 13'($urandom_range(1, MAX_DIM));
        r.dst_width  = 13'($urandom_range(1, MAX_DIM));
        r.dst_height = 13'($urandom_range(1, MAX_DIM));
      end
      default: begin
        // destination near the source so every filter set shows up
        r.src_width  = 13'($urandom_range(1, MAX_DIM));
        r.src_height = 13'($urandom_range(1, MAX_DIM));
        shrink = $urandom_range(1, 4);
        r.dst_width  = (r.src_width / shrink == 0) ? 13'd1 : 13'(r.src_width / shrink);
        shrink = $urandom_range(1, 3);
        r.dst_height = (r.src_height / shrink == 0) ? 13'd1 : 13'(r.src_height / shrink);
      end
    endcase
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    scale_reqs.push_back(mk_req(0, 1, 1, 0, 0, 1, 1));
    scale_reqs.push_back(mk_req(1, 4096, 4096, 4095, 4095, 4096, 4096));
    scale_reqs.push_back(mk_req(2, 4096, 4096, 0, 0, 1, 1));
    scale_reqs.push_back(mk_req(3, 1, 1, 4095, 0, 4096, 4096));
    scale_reqs.push_back(mk_req(0, 640, 480, 10, 20, 320, 240));
    scale_reqs.push_back(mk_req(1, 640, 480, 0, 0, 320, 480));
    scale_reqs.push_back(mk_req(2, 641, 480, 0, 0, 320, 240));
    scale_reqs.push_back(mk_req(3, 1000, 1000, 0, 0, 447, 447));
    scale_reqs.push_back(mk_req(0, 8191, 8191, 4095, 4095, 8191, 8191));
    scale_reqs.push_back(mk_req(1, 100, 100, 5, 5, 0, 100));
    scale_reqs.push_back(mk_req(2, 100, 100, 5, 5, 100, 0));
    scale_reqs.push_back(mk_req(3, 0, 50, 1, 2, 50, 50));
    scale_reqs.push_back(mk_req(0, 50, 0, 1, 2, 50, 50));
    scale_reqs.push_back(mk_req(1, 0, 0, 0, 0, 0, 0));
    scale_reqs.push_back(mk_req(2, 8191, 1, 100, 200, 1, 1));
    scale_reqs.push_back(mk_req(3, 3, 1, 0, 0, 2, 1));
    scale_reqs.push_back(mk_req(0, 1920, 1080, 2048, 1024, 1280, 720));
    scale_reqs.push_back(mk_req(1, 4096, 1, 0, 4095, 1, 4096));
    scale_reqs.push_back(mk_req(2, 5, 5, 0, 0, 5, 1));
    scale_reqs.push_back(mk_req(3, 2, 1, 0, 0, 1, 1));
    for (int i = 0; i < NUM_RANDOM; i++) scale_reqs.push_back(rand_req());
    total_reqs = scale_reqs.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: present pending requests, predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_writes(in_data);
        reqs_accepted <= reqs_accepted + 1;
        if (((cyc / 150) % 4) != 1 && reqs_accepted < total_reqs - QUIET_ITEMS &&
            (reqs_accepted < HOLD_AT - 5 || reqs_accepted > HOLD_AT + 40) &&
            $urandom_range(0, 3) == 0)
          in_gap = $urandom_range(1, 18);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (scale_reqs.size() > 0) begin
          in_data  <= scale_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && reqs_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (((cyc / 150) % 4) != 1 && reqs_accepted < total_reqs - QUIET_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check each accepted write against the oldest prediction
  always @(posedge clk) begin
    wr_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_writes.size() == 0) begin
        $display("%0t: unexpected write: addr %h value %h last %b", $time,
                 out_data.reg_addr, out_data.reg_value, out_data.last_write);
        err_cnt++;
      end else begin
        want = predicted_writes.pop_front();
        if (out_data.reg_addr !== want.reg_addr) begin
          $display("%0t: reg_addr mismatch: expected %h actual %h", $time,
                   want.reg_addr, out_data.reg_addr);
          err_cnt++;
        end
        if (out_data.reg_value !== want.reg_value) begin
          $display("%0t: reg_value mismatch at %h: expected %h actual %h", $time,
                   want.reg_addr, want.reg_value, out_data.reg_value);
          err_cnt++;
        end
        if (out_data.last_write !== want.last_write) begin
          $display("%0t: last_write mismatch at %h: expected %b actual %b", $time,
                   want.reg_addr, want.last_write, out_data.last_write);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    while (reqs_accepted != total_reqs || predicted_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && predicted_writes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== plane_scaler_setup.f =====
rtl/pss_pkg.sv
rtl/pss_prep.sv
rtl/pss_div.sv
rtl/pss_seq.sv
rtl/plane_scaler_setup.sv
bench/tb_plane_scaler_setup.sv
